>>> sv/lec_pkg.sv
package lec_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] STY_CRLF = 2'd0;
  localparam logic [1:0] STY_CR   = 2'd1;
  localparam logic [1:0] STY_LFCR = 2'd2;
  localparam logic [1:0] STY_LF   = 2'd3;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_PASS = 2'd2;
  localparam logic [1:0] PH_CONV = 2'd3;

  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] src;
    logic       held_cr;
    logic       skip;
  } lec_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   marker;
    logic                   last;
  } lec_res_t;

  function automatic logic two_byte(input logic [1:0] sty);
    return (sty == STY_CRLF) || (sty == STY_LFCR);
  endfunction

  function automatic logic [7:0] key_char(input logic [1:0] sty);
    return ((sty == STY_CRLF) || (sty == STY_CR)) ? CH_CR : CH_LF;
  endfunction

  function automatic logic [7:0] seq_second(input logic [1:0] sty);
    return (sty == STY_CRLF) ? CH_LF : CH_CR;
  endfunction

endpackage

>>> sv/lec_core.sv
module lec_core import lec_pkg::*; (
  input  lec_state_t st_i,
  input  logic [1:0] target_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output lec_state_t st_o,
  output lec_res_t   res_o
);

  logic [1:0][7:0] a_bytes, b_bytes;
  logic [1:0]      na, nb;
  logic [1:0][7:0] seq_bytes;
  logic [1:0]      seq_n;
  logic            is_crlf;
  logic [1:0]      src;
  logic            j;
  lec_state_t      nxt;

  always_comb begin
    seq_bytes = {seq_second(target_i), key_char(target_i)};
    seq_n     = two_byte(target_i) ? 2'd2 : 2'd1;
    is_crlf   = (byte_i == CH_CR) || (byte_i == CH_LF);
    a_bytes   = '0;
    b_bytes   = '0;
    na        = 2'd0;
    nb        = 2'd0;
    nxt       = st_i;
    src       = st_i.src;

    unique case (st_i.phase)
      PH_HOLD: begin
        if (st_i.held_cr) begin
          src = (byte_i == CH_LF) ? STY_CRLF : STY_CR;
        end else begin
          src = (byte_i == CH_CR) ? STY_LFCR : STY_LF;
        end
        nxt.src = src;
        if (src == target_i) begin
          a_bytes[0] = st_i.held_cr ? CH_CR : CH_LF;
          na         = 2'd1;
          b_bytes[0] = byte_i;
          nb         = 2'd1;
          nxt.phase  = PH_PASS;
        end else begin
          a_bytes   = seq_bytes;
          na        = seq_n;
          nxt.phase = PH_CONV;
          if (!two_byte(src)) begin
            if (byte_i == key_char(src)) begin
              b_bytes = seq_bytes;
              nb      = seq_n;
            end else if (!is_crlf) begin
              b_bytes[0] = byte_i;
              nb         = 2'd1;
            end
          end
        end
      end
      PH_PASS: begin
        a_bytes[0] = byte_i;
        na         = 2'd1;
      end
      PH_CONV: begin
        if (st_i.skip) begin
          nxt.skip = 1'b0;
        end else if (byte_i == key_char(st_i.src)) begin
          a_bytes  = seq_bytes;
          na       = seq_n;
          nxt.skip = two_byte(st_i.src);
        end else if (!is_crlf) begin
          a_bytes[0] = byte_i;
          na         = 2'd1;
        end
      end
      default: begin
        if (is_crlf) begin
          nxt.held_cr = (byte_i == CH_CR);
          if (last_i) begin
            src = (byte_i == CH_CR) ? STY_CR : STY_LF;
            if (src == target_i) begin
              a_bytes[0] = byte_i;
              na         = 2'd1;
            end else begin
              a_bytes = seq_bytes;
              na      = seq_n;
            end
          end else begin
            nxt.phase = PH_HOLD;
          end
        end else begin
          a_bytes[0] = byte_i;
          na         = 2'd1;
        end
      end
    endcase

    for (int i = 0; i < MaxRes; i++) begin
      j = 1'(3'(i) - {1'b0, na});
      if (3'(i) < {1'b0, na}) begin
        res_o.bytes[i] = a_bytes[1'(i)];
      end else begin
        res_o.bytes[i] = b_bytes[j];
      end
    end
    res_o.cnt    = {1'b0, na} + {1'b0, nb};
    res_o.marker = 1'b0;
    res_o.last   = last_i;
    if (last_i && (res_o.cnt == 3'd0)) begin
      res_o.cnt      = 3'd1;
      res_o.bytes[0] = '0;
      res_o.marker   = 1'b1;
    end

    if (last_i) begin
      nxt = '{phase: PH_SCAN, src: STY_CRLF, held_cr: 1'b0, skip: 1'b0};
    end
    st_o = nxt;
  end

endmodule

>>> sv/lec_outbuf.sv
module lec_outbuf import lec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  lec_res_t   res_i,
  output logic       free_o,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tuser,
  output logic       m_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready
);

  logic [MaxRes-1:0][7:0] bytes_q;
  logic                   marker_q, last_q;
  logic [2:0]             rem_q, rem_d;
  logic [1:0]             idx_q, idx_d;
  logic                   take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign free_o        = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_axis_tready);
  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tdata  = bytes_q[idx_q];
  assign m_axis_tuser  = !marker_q;
  assign m_axis_tlast  = last_q && (rem_q == 3'd1);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (take) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
    if (load_i) begin
      rem_d = res_i.cnt;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= res_i.bytes;
      marker_q <= res_i.marker;
      last_q   <= res_i.last;
    end
  end

endmodule

>>> sv/line_ending_converter.sv
// channel   dir  tdata          tuser       tlast
// s_axis    in   in_byte[7:0]   -           in_last
// m_axis    out  out_byte[7:0]  out_valid   out_last
// apb       cfg  reg 0 at 0x0: target_style[1:0]
//
// An input beat is converted in the cycle it is accepted; its 0 to 4 output
// beats leave a result buffer one per cycle while m_axis_tready is high,
// starting the next cycle, so throughput is one input beat per cycle except
// where a byte expands into several output beats or m_axis_tready is low.
// s_axis_tready is high while the buffer is empty or its final beat is taken.
// Reset clears the conversion state and target_style to CRLF.
module line_ending_converter import lec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tuser,  // out_valid
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lec_state_t st_q, st_d;
  lec_res_t   res;
  logic [1:0] target_q;
  logic       free, acc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, target_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= STY_CRLF;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      target_q <= pwdata[1:0];
    end
  end

  assign s_axis_tready = free;
  assign acc           = s_axis_tvalid && free;

  lec_core u_core (
    .st_i     (st_q),
    .target_i (target_q),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .st_o     (st_d),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_SCAN, src: STY_CRLF, held_cr: 1'b0, skip: 1'b0};
    end else if (acc) begin
      st_q <= st_d;
    end
  end

  lec_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (acc && (res.cnt != 3'd0)),
    .res_i         (res),
    .free_o        (free),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

>>> tb/sv/line_ending_converter_test.sv
module line_ending_converter_test import lec_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TargetStyleAddr = 3'd0;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [15:0] RxStallPattern = 16'b1101_0011_1011_0001;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       last;
  } text_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // in_byte[7:0]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // out_byte[7:0]
  logic        m_axis_tuser;          // out_valid
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  line_ending_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // converter state as predicted
  logic [1:0] tgt_sty = STY_CRLF;
  logic [1:0] src_sty = STY_CRLF;
  logic [1:0] ph = PH_SCAN;
  logic       held_cr = 1'b0;
  logic       skip_next = 1'b0;

  text_beat_t expected_text[$];
  text_beat_t item_out[$];
  text_beat_t want_beat;
  logic [7:0] text_buf[$];

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  rx_mode_e    rx_mode = RX_ALWAYS;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  logic [3:0]  rx_step = 4'd0;

  function automatic void put_char(input logic [7:0] c);
    if (item_out.size() < MaxRes) item_out.push_back('{chr: c, valid: 1'b1, last: 1'b0});
  endfunction

  function automatic void put_line_end();
    case (tgt_sty)
      STY_CRLF: begin
        put_char(CH_CR);
        put_char(CH_LF);
      end
      STY_CR: put_char(CH_CR);
      STY_LFCR: begin
        put_char(CH_LF);
        put_char(CH_CR);
      end
      default: put_char(CH_LF);
    endcase
  endfunction

  function automatic void release_first_key();
    if (src_sty == tgt_sty) begin
      put_char(held_cr ? CH_CR : CH_LF);
      ph = PH_PASS;
    end else begin
      put_line_end();
      ph = PH_CONV;
    end
  endfunction

  // odd style codes are the single-byte ones; styles 2 and 3 key on LF
  function automatic void convert_body(input logic [7:0] c);
    if (skip_next) begin
      skip_next = 1'b0;
    end else if (c == (src_sty[1] ? CH_LF : CH_CR)) begin
      put_line_end();
      if (!src_sty[0]) skip_next = 1'b1;
    end else if (c != CH_CR && c != CH_LF) begin
      put_char(c);
    end
  endfunction

  function automatic void convert_text_byte(input logic [7:0] c, input logic last);
    text_beat_t tail;
    item_out.delete();
    case (ph)
      PH_HOLD: begin
        if (held_cr) src_sty = (c == CH_LF) ? STY_CRLF : STY_CR;
        else src_sty = (c == CH_CR) ? STY_LFCR : STY_LF;
        release_first_key();
        if (ph == PH_PASS) put_char(c);
        else if (src_sty[0]) convert_body(c);
      end
      PH_PASS: put_char(c);
      PH_CONV: convert_body(c);
      default: begin
        if (c == CH_CR || c == CH_LF) begin
          held_cr = (c == CH_CR);
          if (last) begin
            src_sty = held_cr ? STY_CR : STY_LF;
            release_first_key();
          end else begin
            ph = PH_HOLD;
          end
        end else begin
          put_char(c);
        end
      end
    endcase
    if (last) begin
      if (item_out.size() == 0) begin
        item_out.push_back('{chr: 8'h00, valid: 1'b0, last: 1'b1});
      end else begin
        tail = item_out.pop_back();
        tail.last = 1'b1;
        item_out.push_back(tail);
      end
      ph = PH_SCAN;
      src_sty = STY_CRLF;
      held_cr = 1'b0;
      skip_next = 1'b0;
    end
    foreach (item_out[i]) expected_text.push_back(item_out[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %02h/%b/%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want_beat = expected_text.pop_front();
        if (m_axis_tdata !== want_beat.chr)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want_beat.chr));
        if (m_axis_tuser !== want_beat.valid)
          report_mismatch($sformatf("out_valid %b, want %b", m_axis_tuser, want_beat.valid));
        if (m_axis_tlast !== want_beat.last)
          report_mismatch($sformatf("out_last %b, want %b", m_axis_tlast, want_beat.last));
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HoldOffCycles;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 65);
        RX_PATTERN: begin
          m_axis_tready <= RxStallPattern[rx_step];
          rx_step <= rx_step + 4'd1;
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("line_ending_converter_test: errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    convert_text_byte(c, last);
    @(negedge clk_i);
  endtask

  task automatic send_span(input int from, input int upto, input logic ends_text);
    for (int i = from; i < upto; i++) send_byte(text_buf[i], ends_text && (i == upto - 1));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_target(input logic [1:0] sty);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= TargetStyleAddr;
    pwdata <= 32'(sty);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tgt_sty = sty;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic build_text(input logic [1:0] src, input int len);
    int r;
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        case (src)
          STY_CRLF: begin
            text_buf.push_back(CH_CR);
            text_buf.push_back(CH_LF);
          end
          STY_CR: text_buf.push_back(CH_CR);
          STY_LFCR: begin
            text_buf.push_back(CH_LF);
            text_buf.push_back(CH_CR);
          end
          default: text_buf.push_back(CH_LF);
        endcase
      end else if (r < 18) begin
        text_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (r < 25) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        text_buf.push_back(8'($urandom_range(32, 126)));
      end
    end
  endtask

  task automatic test_byte_extremes_and_skip_at_end();
    write_target(STY_LF);
    text_buf = {8'h00, 8'hFF, CH_CR, CH_LF, 8'h7F, CH_CR};
    send_span(0, 6, 1'b1);
  endtask

  task automatic test_first_key_last();
    text_buf = {CH_LF};
    send_span(0, 1, 1'b1);
    write_target(STY_CRLF);
    text_buf = {CH_CR};
    send_span(0, 1, 1'b1);
  endtask

  task automatic test_end_marker();
    write_target(STY_CR);
    text_buf = {CH_LF, 8'h61, CH_CR};
    send_span(0, 3, 1'b1);
  endtask

  task automatic test_full_expansion();
    write_target(STY_CRLF);
    text_buf = {CH_CR, CH_CR};
    send_span(0, 2, 1'b1);
  endtask

  task automatic test_write_mid_text();
    write_target(STY_LFCR);
    text_buf = {8'h71, CH_LF, CH_CR, 8'h72, CH_LF, CH_CR, 8'h73};
    send_span(0, 4, 1'b0);
    write_target(STY_CRLF);
    send_span(4, 7, 1'b1);
    write_target(STY_LF);
    text_buf = {8'h41, CH_CR, 8'h42, CH_CR, 8'h43, CH_CR, 8'h44};
    send_span(0, 3, 1'b0);
    write_target(STY_LFCR);
    send_span(3, 7, 1'b1);
  endtask

  task automatic test_random_texts(input int n_items);
    int sent;
    int len;
    int split_at;
    int r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        write_target(r < 2 ? STY_CRLF : r < 4 ? STY_LF : 2'($urandom_range(0, 3)));
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      build_text(2'($urandom_range(0, 3)), len);
      split_at = 0;
      if (text_buf.size() > 1 && $urandom_range(0, 5) == 0)
        split_at = $urandom_range(1, text_buf.size() - 1);
      if (split_at != 0) begin
        send_span(0, split_at, 1'b0);
        write_target(2'($urandom_range(0, 3)));
        send_span(split_at, text_buf.size(), 1'b1);
      end else begin
        send_span(0, text_buf.size(), 1'b1);
      end
      sent += text_buf.size();
    end
  endtask

  task automatic test_receiver_hold_off();
    wait_idle();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    write_target(STY_CRLF);
    hold_go = 1'b1;
    build_text(STY_LF, 48);
    send_span(0, text_buf.size(), 1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    rx_mode = RX_RANDOM;
    test_byte_extremes_and_skip_at_end();
    test_first_key_last();
    test_end_marker();
    test_full_expansion();
    test_write_mid_text();
    test_random_texts(200);
    test_receiver_hold_off();
    rx_mode = RX_PATTERN;
    test_random_texts(150);
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    test_random_texts(100);
    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("line_ending_converter_test: clean");
    end else begin
      $display("line_ending_converter_test: errors");
    end
    $finish;
  end

endmodule
